// File: rtl/bpfr_pkg.sv
// ----------------------------------------------------------------------------
// bpfr_pkg
// Shared types and constants for the byte pattern find and replace unit.
// ----------------------------------------------------------------------------
package bpfr_pkg;

    // Largest pattern the register map can describe, in bytes.
    localparam int PAT_MAX   = 16;
    // Index into a pattern byte array.
    localparam int PAT_IDX_W = 4;
    // Fill counts and lengths up to PAT_MAX.
    localparam int LEN_W     = 5;
    // Configuration port widths.
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;

    // Pattern bytes, byte 0 in the lowest bits.
    typedef logic [PAT_MAX-1:0][7:0] pat_bytes_t;

    // Register index (byte address divided by eight).
    typedef enum logic [2:0] {
        REG_PAT_LEN = 3'd0,
        REG_SRCH_LO = 3'd1,
        REG_SRCH_HI = 3'd2,
        REG_REPL_LO = 3'd3,
        REG_REPL_HI = 3'd4
    } cfg_reg_t;

    // Control broadcast from the sequencer to every window cell.
    typedef struct packed {
        logic             shift_en;
        logic             replace_en;
        logic [LEN_W-1:0] fill;
        logic [LEN_W-1:0] len;
    } win_ctrl_t;

endpackage

// File: rtl/bpfr_cell.sv
// ----------------------------------------------------------------------------
// bpfr_cell
// One window cell: holds one byte, compares it with its pattern byte and
// hands its byte to the next cell when a new byte enters the window.
// ----------------------------------------------------------------------------
module bpfr_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                clk,
    input  bpfr_pkg::win_ctrl_t ctrl,
    input  logic [7:0]          left_byte,   // byte handed over by the neighbor
    input  bpfr_pkg::pat_bytes_t search,
    input  bpfr_pkg::pat_bytes_t replace,
    output logic [7:0]          base_byte,   // held byte after a replacement
    output logic                eq
);

    localparam logic [bpfr_pkg::LEN_W:0] K_EXT = (bpfr_pkg::LEN_W+1)'(CELL_INDEX);

    logic [7:0]                     byte_reg;
    logic [7:0]                     byte_next;
    logic                           covered;
    logic [bpfr_pkg::LEN_W-1:0]     pos_diff;
    logic [bpfr_pkg::PAT_IDX_W-1:0] pos;

    // The cell holds window position fill-1-CELL_INDEX; it takes part in the
    // compare when that position lies below the pattern length.
    always_comb
    begin
        covered  = ({1'b0, ctrl.fill} > K_EXT) &&
                   ({1'b0, ctrl.fill} <= ({1'b0, ctrl.len} + K_EXT));
        pos_diff = ctrl.fill - bpfr_pkg::LEN_W'(1) - bpfr_pkg::LEN_W'(CELL_INDEX);
        pos      = pos_diff[bpfr_pkg::PAT_IDX_W-1:0];
        eq       = !covered || (byte_reg == search[pos]);
        base_byte = (ctrl.replace_en && covered) ? replace[pos] : byte_reg;
        byte_next = ctrl.shift_en ? left_byte : base_byte;
    end

    // Byte storage.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// File: rtl/bpfr_chain.sv
// ----------------------------------------------------------------------------
// bpfr_chain
// Row of window cells. New bytes enter at cell 0; the oldest held byte sits
// in cell fill-1 and is picked out as the head of the window.
// ----------------------------------------------------------------------------
module bpfr_chain #(
    parameter int NUM_CELLS = 16
) (
    input  logic                 clk,
    input  bpfr_pkg::win_ctrl_t  ctrl,
    input  logic [7:0]           new_byte,
    input  bpfr_pkg::pat_bytes_t search,
    input  bpfr_pkg::pat_bytes_t replace,
    output logic                 all_eq,
    output logic [7:0]           head_byte
);

    logic [NUM_CELLS-1:0][7:0] base_vec;
    logic [NUM_CELLS-1:0]      eq_vec;

    // Cell 0 takes the incoming byte, every other cell its left neighbor.
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        logic [7:0] left_byte;
        if (k == 0)
        begin : g_first
            assign left_byte = new_byte;
        end
        else
        begin : g_rest
            assign left_byte = base_vec[k-1];
        end

        bpfr_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .left_byte (left_byte),
            .search    (search),
            .replace   (replace),
            .base_byte (base_vec[k]),
            .eq        (eq_vec[k])
        );
    end

    assign all_eq = &eq_vec;

    // Head of the window: the cell at fill-1.
    always_comb
    begin
        head_byte = base_vec[0];
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            if (ctrl.fill == bpfr_pkg::LEN_W'(k + 1))
            begin
                head_byte = base_vec[k];
            end
        end
    end

endmodule

// File: rtl/byte_pattern_find_replace_unit.sv
// ----------------------------------------------------------------------------
// byte_pattern_find_replace_unit
// First-match byte pattern find and replace over a stream of bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Signals                        | Contents
//  --------+-----------+--------------------------------+---------------------
//  s_*     | in        | tvalid tready tdata tlast      | data byte, end flag
//  m_*     | out       | tvalid tready tdata tlast tuser| byte, final, replaced
//  APB     | in        | psel penable pwrite paddr ...  | pattern registers
//
//  A byte is taken every cycle in steady state unless the output stalls; each
//  byte leaves the window after the byte that completes a full window enters.
//  The byte with tlast starts a flush: the held bytes (up to the pattern
//  length) leave one per cycle through the output register unless it stalls,
//  and the input stalls until the last of them goes out. A pattern length
//  lowered in mid-stream takes effect with the next byte: the surplus bytes
//  then drain one per cycle unless the output stalls, while the input stalls.
//  Reset empties the window and sets the pattern length to one.
// ----------------------------------------------------------------------------
module byte_pattern_find_replace_unit #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // end_of_data
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,   // final_byte
    output logic                          m_tuser,   // [0] replaced
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfr_pkg::APB_AW-1:0]   paddr,
    input  logic [bpfr_pkg::APB_DW-1:0]   pwdata,
    output logic [bpfr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam logic [bpfr_pkg::LEN_W-1:0] MAX_LEN = bpfr_pkg::LEN_W'(MAX_PATTERN);

    // Configuration registers
    logic [bpfr_pkg::LEN_W-1:0] pat_len_reg;
    logic [63:0]                srch_lo_reg;
    logic [63:0]                srch_hi_reg;
    logic [63:0]                repl_lo_reg;
    logic [63:0]                repl_hi_reg;
    logic                       cfg_wr;
    bpfr_pkg::cfg_reg_t         cfg_sel;

    // Sequencer state
    logic [bpfr_pkg::LEN_W-1:0] fill_reg;
    logic [bpfr_pkg::LEN_W-1:0] fill_next;
    logic                       match_done_reg;
    logic                       match_done_next;
    logic                       flush_reg;
    logic                       flush_next;
    logic                       step_reg;
    logic                       step_next;

    // Output register
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [7:0]                 m_data_reg;
    logic                       m_last_reg;
    logic                       m_user_reg;

    logic [bpfr_pkg::LEN_W-1:0] len;
    logic                       out_free;
    logic                       pending;
    logic                       emit;
    logic                       accept;
    logic                       match_hit;
    logic                       final_emit;
    logic                       all_eq;
    logic [7:0]                 head_byte;
    bpfr_pkg::win_ctrl_t        ctrl;
    bpfr_pkg::pat_bytes_t       search;
    bpfr_pkg::pat_bytes_t       replace;

    // APB register access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = bpfr_pkg::cfg_reg_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= bpfr_pkg::LEN_W'(1);
            srch_lo_reg <= '0;
            srch_hi_reg <= '0;
            repl_lo_reg <= '0;
            repl_hi_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                bpfr_pkg::REG_PAT_LEN: pat_len_reg <= pwdata[bpfr_pkg::LEN_W-1:0];
                bpfr_pkg::REG_SRCH_LO: srch_lo_reg <= pwdata;
                bpfr_pkg::REG_SRCH_HI: srch_hi_reg <= pwdata;
                bpfr_pkg::REG_REPL_LO: repl_lo_reg <= pwdata;
                bpfr_pkg::REG_REPL_HI: repl_hi_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            bpfr_pkg::REG_PAT_LEN: prdata = bpfr_pkg::APB_DW'(pat_len_reg);
            bpfr_pkg::REG_SRCH_LO: prdata = srch_lo_reg;
            bpfr_pkg::REG_SRCH_HI: prdata = srch_hi_reg;
            bpfr_pkg::REG_REPL_LO: prdata = repl_lo_reg;
            bpfr_pkg::REG_REPL_HI: prdata = repl_hi_reg;
            default:               prdata = '0;
        endcase
    end

    // Effective pattern length, clamped to 1..MAX_PATTERN.
    always_comb
    begin
        if (pat_len_reg == '0)
        begin
            len = bpfr_pkg::LEN_W'(1);
        end
        else if (pat_len_reg > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        else
        begin
            len = pat_len_reg;
        end
    end

    assign search  = bpfr_pkg::pat_bytes_t'({srch_hi_reg, srch_lo_reg});
    assign replace = bpfr_pkg::pat_bytes_t'({repl_hi_reg, repl_lo_reg});

    // Sequencer: after a byte has entered, one byte leaves the window per cycle
    // unless the output stalls, while the window is full (or a flush is running);
    // a new byte enters when that leaves the window short of a full pattern again.
    always_comb
    begin
        out_free   = !m_valid_reg || m_tready;
        pending    = flush_reg ? (fill_reg != '0) : (step_reg && (fill_reg >= len));
        emit       = pending && out_free;
        if (flush_reg)
        begin
            s_tready = (fill_reg == bpfr_pkg::LEN_W'(1)) && out_free;
        end
        else
        begin
            s_tready = !pending || ((fill_reg == len) && out_free);
        end
        accept     = s_tvalid && s_tready;
        match_hit  = emit && !match_done_reg && (fill_reg >= len) && all_eq;
        final_emit = emit && flush_reg && (fill_reg == bpfr_pkg::LEN_W'(1));

        fill_next = fill_reg - bpfr_pkg::LEN_W'(emit) + bpfr_pkg::LEN_W'(accept);
        step_next = accept || (step_reg && (fill_next >= len));
        if (final_emit)
        begin
            match_done_next = 1'b0;
            flush_next      = accept && s_tlast;
        end
        else
        begin
            match_done_next = match_done_reg || match_hit;
            flush_next      = flush_reg || (accept && s_tlast);
        end

        ctrl.shift_en   = accept;
        ctrl.replace_en = match_hit;
        ctrl.fill       = fill_reg;
        ctrl.len        = len;

        m_valid_next = emit || (m_valid_reg && !m_tready);
    end

    // Window cells
    bpfr_chain #(
        .NUM_CELLS (MAX_PATTERN)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_byte  (s_tdata),
        .search    (search),
        .replace   (replace),
        .all_eq    (all_eq),
        .head_byte (head_byte)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            match_done_reg <= 1'b0;
            flush_reg      <= 1'b0;
            step_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            match_done_reg <= match_done_next;
            flush_reg      <= flush_next;
            step_reg       <= step_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_data_reg <= head_byte;
            m_last_reg <= final_emit;
            m_user_reg <= match_done_reg || match_hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // The window never holds more bytes than it has cells.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_LEN)
        else $error("window fill exceeds cell count");

    // During a flush a new byte only enters alongside the final byte.
    a_flush_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && flush_reg) |-> final_emit)
        else $error("byte accepted during flush before final byte");

    // A replacement is on the output, flagged in tuser, when match_done_reg rises.
    a_match_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(match_done_reg) |-> (m_tvalid && m_tuser))
        else $error("replacement not reported on output");

    // The final byte always leaves an empty window or one fresh byte.
    a_final_fill: assert property (@(posedge clk) disable iff (!rst_n)
        final_emit |=> (fill_reg == bpfr_pkg::LEN_W'($past(accept))))
        else $error("window not emptied after final byte");

endmodule
